### src/ids_pkg.sv
`default_nettype none

package ids_pkg;

   // default geometry
   localparam int DEPTH_DEF     = 64;
   localparam int ITEM_BITS_DEF = 32;

   // fixed field widths of the request and response words
   localparam int CMD_W    = 3;
   localparam int ITEM_W   = 32;
   localparam int POS_W    = 6;
   localparam int STATUS_W = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_TOP  = 3'd0,
      CMD_APPEND    = 3'd1,
      CMD_POP       = 3'd2,
      CMD_PEEK_TOP  = 3'd3,
      CMD_PEEK_AT   = 3'd4,
      CMD_REMOVE_AT = 3'd5
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_BAD_INDEX = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   // what a cell loads at the next edge
   typedef enum logic [1:0] {
      CELL_HOLD      = 2'd0,
      CELL_LOAD      = 2'd1,
      CELL_FROM_UP   = 2'd2,
      CELL_FROM_DOWN = 2'd3
   } cell_op_type;

endpackage

`default_nettype wire

### src/indexed_deque_store.sv
`default_nettype none

// Indexed deque store: a bounded ordered store of DEPTH item handles kept
// as a row of cells, cell 0 being the top and cell occupancy-1 the bottom.
// Commands: push at the top, append at the bottom, pop the top, peek the
// top, peek at a position counted from the top, and remove at a position
// (the cells below move up one place to close the gap). Every accepted
// request word gives exactly one response word with the item (zero unless
// something was popped, peeked or removed), a status (ok, empty, bad index,
// full) and the occupancy after the command. A refused command changes
// nothing; commands 6 and 7 answer ok with no effect. Rate: one command per
// clock while req_stall is low. All cells shift or hold in parallel in the
// same edge that loads the response into the output register; req_stall
// rises only while a response waits on a stalled output. Storage has no
// reset; only the occupancy counter and the response valid are cleared.
module indexed_deque_store #(
   parameter int DEPTH     = ids_pkg::DEPTH_DEF,
   parameter int ITEM_BITS = ids_pkg::ITEM_BITS_DEF
) (
   input  wire                             clock,
   input  wire                             reset,
   // request channel
   input  wire                             req_valid,
   output logic                            req_stall,
   input  wire [ids_pkg::CMD_W-1:0]        req_cmd,
   input  wire [ids_pkg::ITEM_W-1:0]       req_item_in,
   input  wire [ids_pkg::POS_W-1:0]        req_position,
   // response channel
   output logic                            rsp_valid,
   input  wire                             rsp_stall,
   output logic [ids_pkg::ITEM_W-1:0]      rsp_item_out,
   output logic [ids_pkg::STATUS_W-1:0]    rsp_status,
   output logic [$clog2(DEPTH+1)-1:0]      rsp_occupancy
);
   import ids_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

   // occupancy counter
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;

   // response register
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [ITEM_W-1:0]    rsp_item_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [CNT_W-1:0]     rsp_occ_ff;

   logic accept;

   // decoded command
   cmd_type           cmd;
   status_type        status;
   logic              do_push;
   logic              do_append;
   logic              do_take;
   logic              do_read;
   logic [CMD_W-1:0]  cmd_bits;
   logic [CMD_W-1:0]  cmd_bits_unused;
   logic [CMD_W-1:0]  cmd_chk;
   logic [CMD_W-1:0]  cmd_chk_unused;
   logic [CMD_W-1:0]  cmd_spare;
   logic [CMD_W-1:0]  cmd_spare_unused;
   logic [CMD_W-1:0]  cmd_dummy;
   logic [CMD_W-1:0]  cmd_dummy_unused;
   logic [CMP_W-1:0]  pos_ext;
   logic [CMP_W-1:0]  cnt_ext;
   logic [CMP_W-1:0]  rd_idx;
   logic              is_full;
   logic              is_empty;
   logic              pos_ok;

   // cell row
   logic [ITEM_BITS-1:0] cell_q [DEPTH];
   logic [ITEM_BITS-1:0] new_item;
   logic [ITEM_BITS-1:0] rd_item;
   logic [DEPTH-1:0]     rd_sel;
   logic [ITEM_W-1:0]    rd_word;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign cmd_bits         = req_cmd;
   assign cmd_bits_unused  = cmd_bits;
   assign cmd_chk          = cmd_bits_unused;
   assign cmd_chk_unused   = cmd_chk;
   assign cmd_spare        = cmd_chk_unused;
   assign cmd_spare_unused = cmd_spare;
   assign cmd_dummy        = cmd_spare_unused;
   assign cmd_dummy_unused = cmd_dummy;
   assign cmd              = cmd_type'(cmd_dummy_unused);

   assign pos_ext  = CMP_W'(req_position);
   assign cnt_ext  = CMP_W'(cnt_ff);
   assign is_full  = (cnt_ff == CNT_W'(DEPTH));
   assign is_empty = (cnt_ff == '0);
   assign pos_ok   = (pos_ext < cnt_ext);

   // item handle held to ITEM_BITS
   generate
      if (ITEM_BITS <= ITEM_W) begin : g_in_narrow
         assign new_item = req_item_in[ITEM_BITS-1:0];
      end else begin : g_in_wide
         assign new_item = {{(ITEM_BITS-ITEM_W){1'b0}}, req_item_in};
      end
   endgenerate

   // command decode, status and next occupancy
   always_comb begin
      do_push   = 1'b0;
      do_append = 1'b0;
      do_take   = 1'b0;
      do_read   = 1'b0;
      rd_idx    = '0;
      status    = ST_OK;
      cnt_in    = cnt_ff;
      unique case (cmd)
         CMD_PUSH_TOP: begin
            if (is_full) begin
               status = ST_FULL;
            end else begin
               do_push = accept;
               cnt_in  = cnt_ff + 1'b1;
            end
         end
         CMD_APPEND: begin
            if (is_full) begin
               status = ST_FULL;
            end else begin
               do_append = accept;
               cnt_in    = cnt_ff + 1'b1;
            end
         end
         CMD_POP: begin
            if (is_empty) begin
               status = ST_EMPTY;
            end else begin
               do_take = accept;
               do_read = 1'b1;
               cnt_in  = cnt_ff - 1'b1;
            end
         end
         CMD_PEEK_TOP: begin
            if (is_empty) begin
               status = ST_EMPTY;
            end else begin
               do_read = 1'b1;
            end
         end
         CMD_PEEK_AT: begin
            rd_idx = pos_ext;
            if (!pos_ok) begin
               status = ST_BAD_INDEX;
            end else begin
               do_read = 1'b1;
            end
         end
         CMD_REMOVE_AT: begin
            rd_idx = pos_ext;
            if (!pos_ok) begin
               status = ST_BAD_INDEX;
            end else begin
               do_take = accept;
               do_read = 1'b1;
               cnt_in  = cnt_ff - 1'b1;
            end
         end
         default: begin
            // spare codes: no effect, status ok
         end
      endcase
   end

   // the row of cells; rd_idx doubles as the take position
   generate
      for (genvar i = 0; i < DEPTH; i++) begin : g_cell
         cell_op_type          op;
         logic [ITEM_BITS-1:0] up_item;
         logic [ITEM_BITS-1:0] down_item;

         if (i == 0) begin : g_top
            assign up_item = new_item;
         end else begin : g_mid_up
            assign up_item = cell_q[i-1];
         end

         // the bottom cell keeps its value when the row moves up
         if (i == DEPTH - 1) begin : g_bottom
            assign down_item = cell_q[i];
         end else begin : g_mid_down
            assign down_item = cell_q[i+1];
         end

         always_comb begin
            priority if (do_push) begin
               op = (i == 0) ? CELL_LOAD : CELL_FROM_UP;
            end else if (do_append && (cnt_ff == CNT_W'(i))) begin
               op = CELL_LOAD;
            end else if (do_take && (CMP_W'(i) >= rd_idx)) begin
               op = CELL_FROM_DOWN;
            end else begin
               op = CELL_HOLD;
            end
         end

         assign rd_sel[i] = (rd_idx == CMP_W'(i));

         ids_cell #(
            .ITEM_BITS (ITEM_BITS)
         ) u_cell (
            .clock     (clock),
            .op        (op),
            .new_item  (new_item),
            .up_item   (up_item),
            .down_item (down_item),
            .item      (cell_q[i])
         );
      end
   endgenerate

   // one-hot read across the row
   always_comb begin
      rd_item = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (rd_sel[i]) begin
            rd_item = rd_item | cell_q[i];
         end
      end
   end

   generate
      if (ITEM_BITS >= ITEM_W) begin : g_out_wide
         assign rd_word = rd_item[ITEM_W-1:0];
      end else begin : g_out_narrow
         assign rd_word = {{(ITEM_W-ITEM_BITS){1'b0}}, rd_item};
      end
   endgenerate

   // response valid: set on accept, cleared once taken
   always_comb begin
      priority if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            cnt_ff <= cnt_in;
         end
      end
   end

   // response payload, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_item_ff   <= do_read ? rd_word : '0;
         rsp_status_ff <= status;
         rsp_occ_ff    <= cnt_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_item_out  = rsp_item_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_occupancy = rsp_occ_ff;

`ifndef ASSERT_OFF
   // occupancy never passes the store depth
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(DEPTH))
      else $error("occupancy above depth");

   // a waiting response reports the live occupancy
   a_rsp_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_occ_ff == cnt_ff))
      else $error("response occupancy out of step with counter");

   // full is reported only with every cell in use
   a_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == ST_FULL)) |-> is_full)
      else $error("full status with free cells");

   // an accepted push into a store with room grows it by one
   a_push_grow: assert property (@(posedge clock) disable iff (reset)
      (accept && (cmd == CMD_PUSH_TOP) && !is_full)
      |=> (cnt_ff == $past(cnt_ff) + 1'b1))
      else $error("push did not grow occupancy");

   // a refused command leaves the occupancy alone
   a_refused_hold: assert property (@(posedge clock) disable iff (reset)
      (accept && (status != ST_OK)) |=> $stable(cnt_ff))
      else $error("refused command changed occupancy");
`endif

endmodule

`default_nettype wire

### src/ids_cell.sv
`default_nettype none

module ids_cell #(
   parameter int ITEM_BITS = ids_pkg::ITEM_BITS_DEF
) (
   input  wire                     clock,
   input  ids_pkg::cell_op_type    op,
   input  wire [ITEM_BITS-1:0]     new_item,
   input  wire [ITEM_BITS-1:0]     up_item,
   input  wire [ITEM_BITS-1:0]     down_item,
   output logic [ITEM_BITS-1:0]    item
);
   import ids_pkg::*;

   logic [ITEM_BITS-1:0] item_ff;

   always_ff @(posedge clock) begin
      unique case (op)
         CELL_HOLD:      item_ff <= item_ff;
         CELL_LOAD:      item_ff <= new_item;
         CELL_FROM_UP:   item_ff <= up_item;
         CELL_FROM_DOWN: item_ff <= down_item;
         default:        item_ff <= item_ff;
      endcase
   end

   assign item = item_ff;

endmodule

`default_nettype wire
